/* hw/rtl/first_fit_segment_allocator_assert.svh */
// Assertion macros for the first-fit segment allocator checker.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define FFSA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset.
`define FFSA_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and codes shared by the first-fit segment allocator files.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
    } seg_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_OOM      = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_GROWTH_STEP = 2'd2;
    localparam logic [1:0] CFG_HEADER      = 2'd3;

endpackage

/* hw/rtl/ffsa_ram.sv */
// ----------------------------------------------------------------------------
// ffsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/first_fit_segment_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit heap allocator with coalescing; free and used segment tables
// live in two RAMs and are scanned and shifted one entry per cycle.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  request  | s_valid s_ready s_opcode s_alloc_size   | in
//           | s_free_addr                             |
//  result   | m_valid m_ready m_status m_address      | out
//  config   | cfg_we cfg_index cfg_wdata              | in
//
//  One request at a time. A request runs table scans and insert or remove
//  shifts over the table entries; a heap growth adds a divider pass.
//  The result register lets the next request in while a result waits.
//  Synchronous active-low reset empties both tables (counts only).
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [23:0] s_alloc_size,
    input  logic [31:0] s_free_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_address,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    import ffsa_pkg::*;

    localparam int FA_W = $clog2(FREE_SLOTS);
    localparam int UA_W = $clog2(USED_SLOTS);
    localparam int FC_W = $clog2(FREE_SLOTS + 1);
    localparam int UC_W = $clog2(USED_SLOTS + 1);
    localparam int IX_W = (FC_W > UC_W) ? FC_W : UC_W;
    localparam int SEG_W = $bits(seg_t);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_GROW   = 4'd4;
    localparam logic [3:0] S_SPLIT  = 4'd5;
    localparam logic [3:0] S_USCAN  = 4'd6;
    localparam logic [3:0] S_SHUP   = 4'd7;
    localparam logic [3:0] S_SHDN   = 4'd8;
    localparam logic [3:0] S_FMERGE = 4'd9;
    localparam logic [3:0] S_OKAY   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    localparam logic [1:0] K_AFREE = 2'd0;
    localparam logic [1:0] K_AUSED = 2'd1;
    localparam logic [1:0] K_FUSED = 2'd2;
    localparam logic [1:0] K_FFREE = 2'd3;

    localparam logic TBL_FREE = 1'b0;
    localparam logic TBL_USED = 1'b1;

    // configuration
    logic [31:0] heap_base_reg, heap_limit_reg;
    logic [23:0] growth_step_reg;
    logic [6:0]  header_bytes_reg;

    // control
    logic [3:0] state_reg, state_next, ret_reg, ret_next;
    logic [1:0] kind_reg, kind_next;
    logic       tsel_reg, tsel_next;
    logic [IX_W-1:0] rd_idx_reg, rd_idx_next, pidx_reg, pidx_next, pos_reg, pos_next;
    logic       pv_reg, pv_next;
    logic [FC_W-1:0] fcnt_reg, fcnt_next;
    logic [UC_W-1:0] ucnt_reg, ucnt_next;
    logic [31:0] grown_reg, grown_next;
    logic       m_valid_reg, m_valid_next;

    // request and working data
    logic        op_reg, op_next;
    logic [23:0] size_reg, size_next;
    logic [31:0] faddr_reg, faddr_next;
    logic [24:0] need_reg, need_next;
    logic [31:0] top_reg, top_next, room_reg, room_next;
    logic        fit_got_reg, fit_got_next, tail_got_reg, tail_got_next;
    logic        ins_got_reg, ins_got_next, have_prev_reg, have_prev_next;
    logic [IX_W-1:0] fit_idx_reg, fit_idx_next, tail_idx_reg, tail_idx_next;
    logic [IX_W-1:0] ins_idx_reg, ins_idx_next, seg_idx_reg, seg_idx_next;
    seg_t        fit_reg, fit_next, tail_reg, tail_next;
    seg_t        prev_reg, prev_next, succ_reg, succ_next, ins_data_reg, ins_data_next;
    logic [31:0] seg_s_reg, seg_s_next, seg_l_reg, seg_l_next;
    logic [24:0] d_orig_reg, d_orig_next, d_sh_reg, d_sh_next, rem_reg, rem_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [2:0]  res_st_reg, res_st_next, m_status_reg, m_status_next;
    logic [31:0] res_addr_reg, res_addr_next, m_address_reg, m_address_next;

    // memory ports
    logic            wr_en, wr_tbl;
    logic [IX_W-1:0] wr_addr, rd_ix;
    seg_t            wr_data, rd_seg;
    logic [SEG_W-1:0] f_rdata, u_rdata;

    logic [IX_W-1:0] cnt_cur, p_w;
    logic            pred_w, succ_w;
    logic [24:0]     trial;
    logic [25:0]     grow;
    logic [31:0]     cap;

    ffsa_ram #(.WIDTH(SEG_W), .DEPTH(FREE_SLOTS)) u_free_ram (
        .aclk  (aclk),
        .we    (wr_en && (wr_tbl == TBL_FREE)),
        .waddr (wr_addr[FA_W-1:0]),
        .wdata (wr_data),
        .raddr (rd_ix[FA_W-1:0]),
        .rdata (f_rdata)
    );

    ffsa_ram #(.WIDTH(SEG_W), .DEPTH(USED_SLOTS)) u_used_ram (
        .aclk  (aclk),
        .we    (wr_en && (wr_tbl == TBL_USED)),
        .waddr (wr_addr[UA_W-1:0]),
        .wdata (wr_data),
        .raddr (rd_ix[UA_W-1:0]),
        .rdata (u_rdata)
    );

    assign rd_seg  = (tsel_reg == TBL_USED) ? seg_t'(u_rdata) : seg_t'(f_rdata);
    assign cnt_cur = (tsel_reg == TBL_USED) ? IX_W'(ucnt_reg) : IX_W'(fcnt_reg);
    assign p_w     = ins_got_reg ? ins_idx_reg : IX_W'(fcnt_reg);
    assign pred_w  = have_prev_reg &&
                     (({1'b0, prev_reg.base} + {1'b0, prev_reg.len}) == {1'b0, seg_s_reg});
    assign succ_w  = ins_got_reg &&
                     (({1'b0, seg_s_reg} + {1'b0, seg_l_reg}) == {1'b0, succ_reg.base});
    assign trial   = {rem_reg[23:0], d_sh_reg[24]};
    assign grow    = 26'(d_orig_reg) - 26'(rem_reg) +
                     ((rem_reg != 25'd0) ? 26'(growth_step_reg) : 26'd0);
    assign cap     = (heap_limit_reg < ~heap_base_reg) ? heap_limit_reg : ~heap_base_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        kind_next      = kind_reg;
        tsel_next      = tsel_reg;
        rd_idx_next    = rd_idx_reg;
        pidx_next      = pidx_reg;
        pos_next       = pos_reg;
        pv_next        = 1'b0;
        fcnt_next      = fcnt_reg;
        ucnt_next      = ucnt_reg;
        grown_next     = grown_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_address_next = m_address_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        faddr_next     = faddr_reg;
        need_next      = need_reg;
        top_next       = top_reg;
        room_next      = room_reg;
        fit_got_next   = fit_got_reg;
        tail_got_next  = tail_got_reg;
        ins_got_next   = ins_got_reg;
        have_prev_next = have_prev_reg;
        fit_idx_next   = fit_idx_reg;
        tail_idx_next  = tail_idx_reg;
        ins_idx_next   = ins_idx_reg;
        seg_idx_next   = seg_idx_reg;
        fit_next       = fit_reg;
        tail_next      = tail_reg;
        prev_next      = prev_reg;
        succ_next      = succ_reg;
        ins_data_next  = ins_data_reg;
        seg_s_next     = seg_s_reg;
        seg_l_next     = seg_l_reg;
        d_orig_next    = d_orig_reg;
        d_sh_next      = d_sh_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        res_st_next    = res_st_reg;
        res_addr_next  = res_addr_reg;
        wr_en          = 1'b0;
        wr_tbl         = TBL_FREE;
        wr_addr        = '0;
        wr_data        = rd_seg;
        rd_ix          = rd_idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_opcode;
                    size_next  = s_alloc_size;
                    faddr_next = s_free_addr;
                    state_next = S_START;
                end
            end
            S_START: begin
                top_next       = heap_base_reg + grown_reg;
                res_addr_next  = 32'd0;
                fit_got_next   = 1'b0;
                tail_got_next  = 1'b0;
                ins_got_next   = 1'b0;
                have_prev_next = 1'b0;
                rd_idx_next    = '0;
                if (op_reg == OP_ALLOC) begin
                    if (size_reg == 24'd0) begin
                        res_st_next = ST_NULL;
                        state_next  = S_DONE;
                    end else if (ucnt_reg == UC_W'(USED_SLOTS)) begin
                        res_st_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        need_next  = 25'(size_reg) + 25'(header_bytes_reg);
                        kind_next  = K_AFREE;
                        tsel_next  = TBL_FREE;
                        state_next = S_SCAN;
                    end
                end else begin
                    if (faddr_reg == 32'd0) begin
                        res_st_next = ST_NULL;
                        state_next  = S_DONE;
                    end else begin
                        kind_next  = K_FUSED;
                        tsel_next  = TBL_USED;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (pv_reg) begin
                    case (kind_reg)
                        K_AFREE: begin
                            if (!fit_got_reg && (rd_seg.len >= 32'(need_reg))) begin
                                fit_got_next = 1'b1;
                                fit_idx_next = pidx_reg;
                                fit_next     = rd_seg;
                            end
                            if (!tail_got_reg && (({1'b0, rd_seg.base} + {1'b0, rd_seg.len})
                                                  == {1'b0, top_reg})) begin
                                tail_got_next = 1'b1;
                                tail_idx_next = pidx_reg;
                                tail_next     = rd_seg;
                            end
                            if (!ins_got_reg && (rd_seg.base > top_reg)) begin
                                ins_got_next = 1'b1;
                                ins_idx_next = pidx_reg;
                            end
                        end
                        K_AUSED: begin
                            if (!ins_got_reg && (rd_seg.base > seg_s_reg)) begin
                                ins_got_next = 1'b1;
                                ins_idx_next = pidx_reg;
                            end
                        end
                        K_FUSED: begin
                            if (!fit_got_reg && (({1'b0, rd_seg.base} + 33'(header_bytes_reg))
                                                 == {1'b0, faddr_reg})) begin
                                fit_got_next = 1'b1;
                                fit_idx_next = pidx_reg;
                                seg_s_next   = rd_seg.base;
                                seg_l_next   = rd_seg.len;
                            end
                        end
                        default: begin
                            if (!ins_got_reg) begin
                                if (rd_seg.base > seg_s_reg) begin
                                    ins_got_next = 1'b1;
                                    ins_idx_next = pidx_reg;
                                    succ_next    = rd_seg;
                                end else begin
                                    have_prev_next = 1'b1;
                                    prev_next      = rd_seg;
                                end
                            end
                        end
                    endcase
                end
                if (rd_idx_reg < cnt_cur) begin
                    rd_ix       = rd_idx_reg;
                    pv_next     = 1'b1;
                    pidx_next   = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + IX_W'(1);
                end else if (!pv_reg) begin
                    case (kind_reg)
                        K_AFREE: begin
                            if (fit_got_reg) begin
                                seg_s_next   = fit_reg.base;
                                seg_l_next   = fit_reg.len;
                                seg_idx_next = fit_idx_reg;
                                state_next   = S_SPLIT;
                            end else if (growth_step_reg == 24'd0) begin
                                res_st_next = ST_OOM;
                                state_next  = S_DONE;
                            end else begin
                                room_next    = (grown_reg < cap) ? cap - grown_reg : 32'd0;
                                d_orig_next  = tail_got_reg ?
                                               25'(32'(need_reg) - tail_reg.len) : need_reg;
                                d_sh_next    = tail_got_reg ?
                                               25'(32'(need_reg) - tail_reg.len) : need_reg;
                                rem_next     = '0;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                        end
                        K_AUSED: begin
                            tsel_next     = TBL_USED;
                            pos_next      = ins_got_reg ? ins_idx_reg : IX_W'(ucnt_reg);
                            rd_idx_next   = IX_W'(ucnt_reg);
                            ins_data_next = '{base: seg_s_reg, len: 32'(need_reg)};
                            ret_next      = S_OKAY;
                            state_next    = S_SHUP;
                        end
                        K_FUSED: begin
                            if (!fit_got_reg) begin
                                res_st_next = ST_NOTALLOC;
                                state_next  = S_DONE;
                            end else begin
                                ins_got_next   = 1'b0;
                                have_prev_next = 1'b0;
                                rd_idx_next    = '0;
                                kind_next      = K_FFREE;
                                tsel_next      = TBL_FREE;
                            end
                        end
                        default: begin
                            if (!pred_w && !succ_w && (fcnt_reg == FC_W'(FREE_SLOTS))) begin
                                res_st_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                tsel_next   = TBL_USED;
                                pos_next    = fit_idx_reg;
                                rd_idx_next = fit_idx_reg + IX_W'(1);
                                ret_next    = S_FMERGE;
                                state_next  = S_SHDN;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                d_sh_next    = {d_sh_reg[23:0], 1'b0};
                rem_next     = (trial >= 25'(growth_step_reg)) ?
                               trial - 25'(growth_step_reg) : trial;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd24) begin
                    state_next = S_GROW;
                end
            end
            S_GROW: begin
                if (32'(grow) > room_reg) begin
                    res_st_next = ST_OOM;
                    state_next  = S_DONE;
                end else if (tail_got_reg) begin
                    grown_next   = grown_reg + 32'(grow);
                    seg_s_next   = tail_reg.base;
                    seg_l_next   = tail_reg.len + 32'(grow);
                    seg_idx_next = tail_idx_reg;
                    state_next   = S_SPLIT;
                end else if (fcnt_reg == FC_W'(FREE_SLOTS)) begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    grown_next    = grown_reg + 32'(grow);
                    seg_s_next    = top_reg;
                    seg_l_next    = 32'(grow);
                    seg_idx_next  = p_w;
                    tsel_next     = TBL_FREE;
                    pos_next      = p_w;
                    rd_idx_next   = IX_W'(fcnt_reg);
                    ins_data_next = '{base: top_reg, len: 32'(grow)};
                    ret_next      = S_SPLIT;
                    state_next    = S_SHUP;
                end
            end
            S_SPLIT: begin
                if (seg_l_reg == 32'(need_reg)) begin
                    tsel_next   = TBL_FREE;
                    pos_next    = seg_idx_reg;
                    rd_idx_next = seg_idx_reg + IX_W'(1);
                    ret_next    = S_USCAN;
                    state_next  = S_SHDN;
                end else begin
                    wr_en      = 1'b1;
                    wr_tbl     = TBL_FREE;
                    wr_addr    = seg_idx_reg;
                    wr_data    = '{base: seg_s_reg + 32'(need_reg),
                                   len:  seg_l_reg - 32'(need_reg)};
                    state_next = S_USCAN;
                end
            end
            S_USCAN: begin
                ins_got_next = 1'b0;
                rd_idx_next  = '0;
                kind_next    = K_AUSED;
                tsel_next    = TBL_USED;
                state_next   = S_SCAN;
            end
            S_SHUP: begin
                if (pv_reg) begin
                    wr_en   = 1'b1;
                    wr_tbl  = tsel_reg;
                    wr_addr = pidx_reg + IX_W'(1);
                    wr_data = rd_seg;
                end
                if (rd_idx_reg > pos_reg) begin
                    rd_ix       = rd_idx_reg - IX_W'(1);
                    pv_next     = 1'b1;
                    pidx_next   = rd_idx_reg - IX_W'(1);
                    rd_idx_next = rd_idx_reg - IX_W'(1);
                end else if (!pv_reg) begin
                    wr_en   = 1'b1;
                    wr_tbl  = tsel_reg;
                    wr_addr = pos_reg;
                    wr_data = ins_data_reg;
                    if (tsel_reg == TBL_USED) begin
                        ucnt_next = ucnt_reg + UC_W'(1);
                    end else begin
                        fcnt_next = fcnt_reg + FC_W'(1);
                    end
                    state_next = ret_reg;
                end
            end
            S_SHDN: begin
                if (pv_reg) begin
                    wr_en   = 1'b1;
                    wr_tbl  = tsel_reg;
                    wr_addr = pidx_reg - IX_W'(1);
                    wr_data = rd_seg;
                end
                if (rd_idx_reg < cnt_cur) begin
                    rd_ix       = rd_idx_reg;
                    pv_next     = 1'b1;
                    pidx_next   = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + IX_W'(1);
                end else if (!pv_reg) begin
                    if (tsel_reg == TBL_USED) begin
                        ucnt_next = ucnt_reg - UC_W'(1);
                    end else begin
                        fcnt_next = fcnt_reg - FC_W'(1);
                    end
                    state_next = ret_reg;
                end
            end
            S_FMERGE: begin
                wr_tbl = TBL_FREE;
                if (pred_w && succ_w) begin
                    wr_en       = 1'b1;
                    wr_addr     = p_w - IX_W'(1);
                    wr_data     = '{base: prev_reg.base,
                                    len:  prev_reg.len + seg_l_reg + succ_reg.len};
                    tsel_next   = TBL_FREE;
                    pos_next    = p_w;
                    rd_idx_next = p_w + IX_W'(1);
                    ret_next    = S_OKAY;
                    state_next  = S_SHDN;
                end else if (pred_w) begin
                    wr_en      = 1'b1;
                    wr_addr    = p_w - IX_W'(1);
                    wr_data    = '{base: prev_reg.base, len: prev_reg.len + seg_l_reg};
                    state_next = S_OKAY;
                end else if (succ_w) begin
                    wr_en      = 1'b1;
                    wr_addr    = p_w;
                    wr_data    = '{base: seg_s_reg, len: succ_reg.len + seg_l_reg};
                    state_next = S_OKAY;
                end else begin
                    tsel_next     = TBL_FREE;
                    pos_next      = p_w;
                    rd_idx_next   = IX_W'(fcnt_reg);
                    ins_data_next = '{base: seg_s_reg, len: seg_l_reg};
                    ret_next      = S_OKAY;
                    state_next    = S_SHUP;
                end
            end
            S_OKAY: begin
                res_st_next   = ST_OK;
                res_addr_next = (op_reg == OP_ALLOC) ?
                                seg_s_reg + 32'(header_bytes_reg) : 32'd0;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = res_st_reg;
                    m_address_next = res_addr_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg    <= 32'd0;
            heap_limit_reg   <= 32'd1048576;
            growth_step_reg  <= 24'd4096;
            header_bytes_reg <= 7'd24;
            state_reg        <= S_IDLE;
            pv_reg           <= 1'b0;
            fcnt_reg         <= '0;
            ucnt_reg         <= '0;
            grown_reg        <= 32'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_HEAP_BASE:   heap_base_reg    <= cfg_wdata;
                    CFG_HEAP_LIMIT:  heap_limit_reg   <= cfg_wdata;
                    CFG_GROWTH_STEP: growth_step_reg  <= cfg_wdata[23:0];
                    CFG_HEADER:      header_bytes_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            state_reg   <= state_next;
            pv_reg      <= pv_next;
            fcnt_reg    <= fcnt_next;
            ucnt_reg    <= ucnt_next;
            grown_reg   <= grown_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg       <= ret_next;
        kind_reg      <= kind_next;
        tsel_reg      <= tsel_next;
        rd_idx_reg    <= rd_idx_next;
        pidx_reg      <= pidx_next;
        pos_reg       <= pos_next;
        m_status_reg  <= m_status_next;
        m_address_reg <= m_address_next;
        op_reg        <= op_next;
        size_reg      <= size_next;
        faddr_reg     <= faddr_next;
        need_reg      <= need_next;
        top_reg       <= top_next;
        room_reg      <= room_next;
        fit_got_reg   <= fit_got_next;
        tail_got_reg  <= tail_got_next;
        ins_got_reg   <= ins_got_next;
        have_prev_reg <= have_prev_next;
        fit_idx_reg   <= fit_idx_next;
        tail_idx_reg  <= tail_idx_next;
        ins_idx_reg   <= ins_idx_next;
        seg_idx_reg   <= seg_idx_next;
        fit_reg       <= fit_next;
        tail_reg      <= tail_next;
        prev_reg      <= prev_next;
        succ_reg      <= succ_next;
        ins_data_reg  <= ins_data_next;
        seg_s_reg     <= seg_s_next;
        seg_l_reg     <= seg_l_next;
        d_orig_reg    <= d_orig_next;
        d_sh_reg      <= d_sh_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        res_st_reg    <= res_st_next;
        res_addr_reg  <= res_addr_next;
    end

endmodule

/* hw/rtl/ffsa_checker.sv */
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks for the first-fit segment allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_assert.svh"

module ffsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_address
);

    import ffsa_pkg::*;

    `FFSA_ASSERT_RST(a_reset_quiet, (!m_valid && s_ready), "result or busy after reset")
    `FFSA_ASSERT_NEXT(a_one_request, (s_valid && s_ready), (!s_ready), "second request taken")
    `FFSA_ASSERT(a_err_addr, (m_valid && (m_status != ST_OK)), (m_address == 32'd0), "error with address")
    `FFSA_ASSERT(a_status_range, m_valid, (m_status <= ST_FULL), "status code out of range")
    `FFSA_ASSERT_NEXT(a_hold, (m_valid && !m_ready), (m_valid && $stable(m_status) && $stable(m_address)), "result dropped")

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_address (m_address)
);

/* tb/sv/first_fit_segment_allocator_checker.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_checker
// Watches the request and result channels, keeps its own copy of the free
// and used segment tables, predicts the status and address of every request
// and compares them with the results in order.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_checker #(
    parameter int FREE_SLOTS = 64,
    parameter int USED_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_opcode,
    input  logic [23:0] s_alloc_size,
    input  logic [31:0] s_free_addr,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_address,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending_results,
    output int          live_blocks
);

    import ffsa_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] address;
    } outcome_t;

    logic [31:0] base_q, limit_q, step_q, hdr_q;
    logic [31:0] fs[FREE_SLOTS], fl[FREE_SLOTS];
    logic [31:0] us[USED_SLOTS], ul[USED_SLOTS];
    int          nfree, nused;
    logic [31:0] grown;
    outcome_t    awaited[$];

    // first index whose start lies above s
    function automatic int free_slot_after(logic [31:0] s);
        int i;
        i = 0;
        while (i < nfree && fs[i] <= s) i++;
        return i;
    endfunction

    function automatic int used_slot_after(logic [31:0] s);
        int i;
        i = 0;
        while (i < nused && us[i] <= s) i++;
        return i;
    endfunction

    function automatic void free_insert(int p, logic [31:0] s, logic [31:0] l);
        for (int k = nfree; k > p; k--) begin
            fs[k] = fs[k-1];
            fl[k] = fl[k-1];
        end
        fs[p] = s;
        fl[p] = l;
        nfree++;
    endfunction

    function automatic void free_remove(int p);
        for (int k = p; k < nfree - 1; k++) begin
            fs[k] = fs[k+1];
            fl[k] = fl[k+1];
        end
        nfree--;
    endfunction

    function automatic void used_insert(int p, logic [31:0] s, logic [31:0] l);
        for (int k = nused; k > p; k--) begin
            us[k] = us[k-1];
            ul[k] = ul[k-1];
        end
        us[p] = s;
        ul[p] = l;
        nused++;
    endfunction

    function automatic void used_remove(int p);
        for (int k = p; k < nused - 1; k++) begin
            us[k] = us[k+1];
            ul[k] = ul[k+1];
        end
        nused--;
    endfunction

    function automatic outcome_t allocate(logic [23:0] size);
        outcome_t    r;
        logic [31:0] need, s;
        logic [63:0] top, cap, room, tail_len, units, grow;
        int          i, tail;
        bit          found;
        r = '{ST_OK, 32'd0};
        found = 0;
        if (size == 0) begin
            r.status = ST_NULL;
            return r;
        end
        if (nused >= USED_SLOTS) begin
            r.status = ST_FULL;
            return r;
        end
        need = {8'd0, size} + hdr_q;
        for (i = 0; i < nfree; i++)
            if (fl[i] >= need) begin
                found = 1;
                break;
            end
        if (!found) begin
            top = {32'd0, base_q} + grown;
            cap = limit_q;
            if (64'hFFFF_FFFF - base_q < cap) cap = 64'hFFFF_FFFF - base_q;
            room = (grown < cap) ? cap - grown : 64'd0;
            if (step_q == 0) begin
                r.status = ST_OOM;
                return r;
            end
            tail = nfree;
            tail_len = 0;
            for (int j = 0; j < nfree; j++)
                if ({32'd0, fs[j]} + fl[j] == top) begin
                    tail = j;
                    tail_len = fl[j];
                    break;
                end
            units = ({32'd0, need} - tail_len + step_q - 1) / step_q;
            grow = units * step_q;
            if (grow > room) begin
                r.status = ST_OOM;
                return r;
            end
            if (tail < nfree) begin
                fl[tail] += grow[31:0];
                i = tail;
            end else begin
                if (nfree >= FREE_SLOTS) begin
                    r.status = ST_FULL;
                    return r;
                end
                i = free_slot_after(top[31:0]);
                free_insert(i, top[31:0], grow[31:0]);
            end
            grown += grow[31:0];
        end
        s = fs[i];
        if (fl[i] == need) free_remove(i);
        else begin
            fs[i] = s + need;
            fl[i] -= need;
        end
        used_insert(used_slot_after(s), s, need);
        r.address = s + hdr_q;
        return r;
    endfunction

    function automatic logic [2:0] release_block(logic [31:0] addr);
        int          u, p;
        logic [31:0] s, l;
        bit          pred, succ;
        if (addr == 0) return ST_NULL;
        for (u = 0; u < nused; u++)
            if ({32'd0, us[u]} + hdr_q == {32'd0, addr}) break;
        if (u >= nused) return ST_NOTALLOC;
        s = us[u];
        l = ul[u];
        p = free_slot_after(s);
        pred = p > 0 && {32'd0, fs[p-1]} + fl[p-1] == {32'd0, s};
        succ = p < nfree && {32'd0, s} + l == {32'd0, fs[p]};
        if (!pred && !succ && nfree >= FREE_SLOTS) return ST_FULL;
        used_remove(u);
        if (pred && succ) begin
            fl[p-1] += l + fl[p];
            free_remove(p);
        end else if (pred) fl[p-1] += l;
        else if (succ) begin
            fs[p] = s;
            fl[p] += l;
        end else free_insert(p, s, l);
        return ST_OK;
    endfunction

    always @(posedge aclk) begin
        outcome_t exp_r;
        if (!aresetn) begin
            base_q  <= 32'd0;
            limit_q <= 32'd1048576;
            step_q  <= 32'd4096;
            hdr_q   <= 32'd24;
            nfree = 0;
            nused = 0;
            grown = 0;
            awaited.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HEAP_BASE:   base_q  <= cfg_wdata;
                    CFG_HEAP_LIMIT:  limit_q <= cfg_wdata;
                    CFG_GROWTH_STEP: step_q  <= {8'd0, cfg_wdata[23:0]};
                    CFG_HEADER:      hdr_q   <= {25'd0, cfg_wdata[6:0]};
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_ALLOC) exp_r = allocate(s_alloc_size);
                else exp_r = '{release_block(s_free_addr), 32'd0};
                awaited.push_back(exp_r);
            end
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    $error("unexpected result: status %0d address %h", m_status, m_address);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = awaited.pop_front();
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d actual %0d", exp_r.status, m_status);
                        fail_count <= fail_count + 1;
                    end
                    if (m_address !== exp_r.address) begin
                        $error("address: expected %h actual %h", exp_r.address, m_address);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_results <= awaited.size();
        live_blocks <= nused;
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives alloc and free requests with random gaps and stalls through several
// heap settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import ffsa_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0, s_opcode = 0;
    logic [23:0] s_alloc_size = 0;
    logic [31:0] s_free_addr = 0;
    logic        s_ready, m_valid, m_ready = 0;
    logic [2:0]  m_status;
    logic [31:0] m_address;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_wdata = 0;
    int          fail_count, pending_results, live_blocks;
    bit          hold_sink = 0;
    bit          stim_done = 0;
    logic [31:0] handed_out[$];

    always #10 aclk = ~aclk;

    first_fit_segment_allocator uut (.*);
    first_fit_segment_allocator_checker chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 200);
    endfunction

    // sink: random stalls, plus one long hold-off on request
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready <= 0;
                repeat (6000) @(negedge aclk);
                hold_sink = 0;
            end
            g = gap_len();
            if (g == 0 || $urandom_range(0, 3) == 0) m_ready <= 1;
            else begin
                m_ready <= 0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    // collect returned addresses so frees can hit live blocks
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready && m_status == ST_OK && m_address != 0)
            handed_out.push_back(m_address);

    task automatic send(logic op, logic [23:0] sz, logic [31:0] fa);
        @(negedge aclk);
        s_valid <= 1;
        s_opcode <= op;
        s_alloc_size <= sz;
        s_free_addr <= fa;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid <= 0;
    endtask

    task automatic settle();
        while (pending_results != 0) @(negedge aclk);
        repeat (2000) @(negedge aclk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic traffic(int n, int maxsz);
        int          r, k;
        logic [31:0] a;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) send(OP_ALLOC, 24'($urandom_range(1, maxsz)), $urandom);
            else if (r < 85 && handed_out.size() > 0) begin
                k = $urandom_range(0, handed_out.size() - 1);
                a = handed_out[k];
                handed_out.delete(k);
                send(OP_FREE, 24'($urandom), a);
            end else if (r < 90) send(OP_ALLOC, 24'($urandom), $urandom);
            else if (r < 95) send(OP_FREE, 24'($urandom), $urandom);
            else if (r < 97) send(OP_ALLOC, 0, $urandom);
            else send(OP_FREE, 24'($urandom), 0);
            if ($urandom_range(0, 3) == 0) repeat (gap_len()) @(negedge aclk);
        end
    endtask

    task automatic release_all();
        while (handed_out.size() > 0) send(OP_FREE, 24'($urandom), handed_out.pop_front());
        settle();
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed, reset settings
        send(OP_ALLOC, 0, 0);
        send(OP_FREE, 0, 0);
        send(OP_FREE, 24'hFFFFFF, 32'hFFFFFFFF);
        send(OP_ALLOC, 1, 0);
        send(OP_ALLOC, 4096, 0);
        send(OP_ALLOC, 24'hFFFFFF, 0);
        send(OP_ALLOC, 100, 0);
        settle();
        send(OP_FREE, 0, 32'h1234);
        for (int i = 0; i < 3 && handed_out.size() > 0; i++)
            send(OP_FREE, 0, handed_out.pop_back());
        settle();
        // fill used table to full, then drain
        for (int i = 0; i < 66; i++) send(OP_ALLOC, 8, 0);
        settle();
        // free every other block to fragment the free table
        for (int i = 0; i < handed_out.size(); i += 2) send(OP_FREE, 0, handed_out[i]);
        settle();
        for (int i = handed_out.size() - 1; i >= 0; i -= 2) handed_out.delete(i & ~1);
        release_all();

        // long receiver hold-off while requests keep coming
        hold_sink = 1;
        traffic(40, 500);
        settle();

        traffic(500, 3000);
        release_all();

        // high base near top of address space, zero header, odd step
        set_reg(CFG_HEAP_BASE, 32'hFFFF_0000);
        set_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        set_reg(CFG_GROWTH_STEP, 32'd1);
        set_reg(CFG_HEADER, 32'd0);
        traffic(300, 2000);
        release_all();

        // 64-byte header, big step, tiny limit
        set_reg(CFG_HEAP_BASE, 32'h0000_1000);
        set_reg(CFG_HEAP_LIMIT, 32'd0);
        set_reg(CFG_GROWTH_STEP, 32'hFFFFFF);
        set_reg(CFG_HEADER, 32'd64);
        traffic(30, 100);
        settle();
        set_reg(CFG_HEAP_LIMIT, 32'h0300_0000);
        traffic(40, 24'hFFFFFF);
        release_all();

        // growth step of zero, header change with live blocks
        set_reg(CFG_GROWTH_STEP, 32'd0);
        traffic(40, 4000);
        settle();
        set_reg(CFG_GROWTH_STEP, 32'd777);
        set_reg(CFG_HEADER, 32'd7);
        set_reg(CFG_HEAP_LIMIT, 32'd200000);
        traffic(300, 1500);
        settle();
        set_reg(CFG_HEADER, 32'd16);
        traffic(550, 800);
        settle();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0) $display("first_fit_segment_allocator test passed");
        else $display("first_fit_segment_allocator test failed");
        $finish;
    end

    initial begin
        #300000000;
        $display("first_fit_segment_allocator test failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_ram.sv
hw/rtl/first_fit_segment_allocator.sv
hw/rtl/ffsa_checker.sv
tb/sv/first_fit_segment_allocator_checker.sv
tb/sv/testbench.sv
